// ===== rtl/core/gtbd_pkg.sv =====
// Package: constants, codes and types of the Goertzel tone bank detector.
`default_nettype none
package gtbd_pkg;
   localparam int NUM_TONES  = 32;
   localparam int TONE_W     = $clog2(NUM_TONES);
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int POWER_W    = 48;
   localparam int SUM_W      = POWER_W + $clog2(NUM_TONES) + 2;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_LOAD   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_MARGIN = 1'd1;

   localparam logic [15:0] BLOCK_LENGTH_RESET  = 16'd1024;
   localparam logic [31:0] DETECT_MARGIN_RESET = 32'h8000_0000;
   localparam logic [POWER_W-1:0] POWER_MAX    = '1;

   typedef struct packed {
      logic               done;
      logic [POWER_W-1:0] power;
   } pow_stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/gtbd_if.sv =====
// Interfaces: request and result channels of the tone bank detector.
`default_nettype none
interface gtbd_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic signed [15:0] sample;
   logic [4:0]        tone_select;
   logic signed [15:0] coef_value;
   modport source (output valid, kind, sample, tone_select, coef_value, input ready);
   modport sink   (input valid, kind, sample, tone_select, coef_value, output ready);
endinterface

interface gtbd_rsp_if;
   logic        valid;
   logic        ready;
   logic        tone_detected;
   logic [4:0]  peak_tone;
   logic [47:0] peak_power;
   modport source (output valid, tone_detected, peak_tone, peak_power, input ready);
   modport sink   (input valid, tone_detected, peak_tone, peak_power, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gtbd_pow_unit.sv =====
// Power unit: one tone's power, computed step by step on a shared 33x33 multiplier.
`default_nettype none
module gtbd_pow_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                run,
   input  wire logic signed [31:0]  d1,
   input  wire logic signed [31:0]  d2,
   input  wire logic signed [15:0]  coef,
   output gtbd_pkg::pow_stat_type   stat
);
   import gtbd_pkg::*;

   typedef enum logic [6:0] {
      ST_SQ1   = 7'b0000001,
      ST_SQ2   = 7'b0000010,
      ST_CROSS = 7'b0000100,
      ST_CLO   = 7'b0001000,
      ST_CHI   = 7'b0010000,
      ST_SUB   = 7'b0100000,
      ST_FIN   = 7'b1000000
   } step_type;

   step_type            step_ff, step_in;
   logic signed [65:0]  prod_ff;
   logic signed [79:0]  acc_ff;
   logic signed [31:0]  thi_ff;
   logic signed [32:0]  op_a, op_b;
   logic signed [65:0]  mul;
   logic signed [79:0]  rnd;
   logic [65:0]         quo;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         ST_SQ1:   begin op_a = 33'(d1);   op_b = 33'(d1); end
         ST_SQ2:   begin op_a = 33'(d2);   op_b = 33'(d2); end
         ST_CROSS: begin op_a = 33'(d1);   op_b = 33'(d2); end
         ST_CLO:   begin op_a = 33'(coef); op_b = $signed({1'b0, prod_ff[31:0]}); end
         ST_CHI:   begin op_a = 33'(coef); op_b = 33'(thi_ff); end
         default:  begin op_a = '0;        op_b = '0; end
      endcase
   end

   assign mul = op_a * op_b;

   always_comb begin
      unique case (step_ff)
         ST_SQ1:   step_in = ST_SQ2;
         ST_SQ2:   step_in = ST_CROSS;
         ST_CROSS: step_in = ST_CLO;
         ST_CLO:   step_in = ST_CHI;
         ST_CHI:   step_in = ST_SUB;
         ST_SUB:   step_in = ST_FIN;
         ST_FIN:   step_in = ST_SQ1;
         default:  step_in = ST_SQ1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || !run) begin
         step_ff <= ST_SQ1;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul;
      case (step_ff)
         ST_SQ1:   acc_ff <= '0;
         ST_SQ2:   acc_ff <= acc_ff + (80'(prod_ff) <<< 14);
         ST_CROSS: acc_ff <= acc_ff + (80'(prod_ff) <<< 14);
         ST_CLO:   thi_ff <= prod_ff[63:32];
         ST_CHI:   acc_ff <= acc_ff - 80'(prod_ff);
         ST_SUB:   acc_ff <= acc_ff - (80'(prod_ff) <<< 32);
         default:  acc_ff <= acc_ff;
      endcase
   end

   assign rnd = acc_ff + 80'sd8192;
   assign quo = rnd[79:14];

   always_comb begin
      stat.done = run && (step_ff == ST_FIN);
      if (rnd[79]) begin
         stat.power = '0;
      end else if (|quo[65:POWER_W]) begin
         stat.power = POWER_MAX;
      end else begin
         stat.power = quo[POWER_W-1:0];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/goertzel_tone_bank_detector_unit.sv =====
// Top level: Goertzel tone bank detector with delay and coefficient memories.
//
// req_chan takes items: sample (kind 0), coefficient load (kind 1), clear (kind 2).
// A sample sweeps the bank, one tone per cycle through the delay memory;
// no new item is accepted until the sweep is done.
// Load and clear items do not leave S_IDLE; kind 3 is dropped.
// At the end of a block a power sweep follows on one shared multiplier:
// each tone's power in turn, then S_DONE compares the peak and posts the result.
// rsp_chan holds one result in an output register; new items are accepted
// while it waits. If a second result is due while the first is still held,
// the block stalls until rsp_chan.ready.
// csr_wr_en writes block_length (index 0) or detect_margin (index 1).
// Reset: delays read as zero through per-tone valid bits, counter and peak
// index zero, registers at their defaults; coefficients undefined until loaded.
`default_nettype none
module goertzel_tone_bank_detector_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   gtbd_req_if.sink                               req_chan,
   gtbd_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [gtbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gtbd_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import gtbd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_UPD  = 4'b0010,
      S_POW  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [TONE_W-1:0]    idx_ff, idx_in;
   logic [15:0]          blen_ff;
   logic [31:0]          margin_ff;
   logic [15:0]          cnt_ff;
   logic [15:0]          cnt_in;
   logic [4:0]           last_peak_ff;
   logic [4:0]           pidx_ff;
   logic [POWER_W-1:0]   peak_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic signed [15:0]   smp_ff;
   logic [NUM_TONES-1:0] valid_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_det_ff;
   logic [4:0]           rsp_tone_ff;
   logic [POWER_W-1:0]   rsp_power_ff;

   logic [63:0]          dmem [NUM_TONES];
   logic [15:0]          cmem [NUM_TONES];
   logic [63:0]          drd_ff;
   logic [15:0]          crd_ff;
   logic                 dval_ff;

   logic                 accept, last_tone, post, hit;
   logic signed [31:0]   d1, d2;
   logic signed [47:0]   cprod;
   logic signed [48:0]   cround;
   logic signed [34:0]   vsum;
   logic signed [31:0]   vsat;
   logic [SUM_W-1:0]     peak_n, limit_n;
   pow_stat_type         pstat;

   assign accept    = req_chan.valid && req_chan.ready;
   assign last_tone = (idx_ff == TONE_W'(NUM_TONES - 1));
   assign req_chan.ready = (state_ff == S_IDLE);
   assign cnt_in    = cnt_ff + 16'd1;
   assign post      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign d1 = dval_ff ? $signed(drd_ff[63:32]) : 32'sd0;
   assign d2 = dval_ff ? $signed(drd_ff[31:0])  : 32'sd0;

   assign cprod  = $signed(crd_ff) * d1;
   assign cround = (49'(cprod) + 49'sd8192) >>> 14;
   assign vsum   = 35'(smp_ff) + 35'(cround) - 35'(d2);
   always_comb begin
      if (vsum > 35'sd2147483647) begin
         vsat = 32'sh7FFF_FFFF;
      end else if (vsum < -35'sd2147483648) begin
         vsat = 32'sh8000_0000;
      end else begin
         vsat = vsum[31:0];
      end
   end

   assign peak_n  = SUM_W'(peak_ff) * SUM_W'(NUM_TONES);
   assign limit_n = sum_ff + SUM_W'(margin_ff) * SUM_W'(NUM_TONES);
   assign hit     = peak_n > limit_n;

   gtbd_pow_unit u_pow (
      .clock (clock),
      .reset (reset),
      .run   (state_ff == S_POW),
      .d1    (d1),
      .d2    (d2),
      .coef  ($signed(crd_ff)),
      .stat  (pstat)
   );

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept && req_chan.kind == KIND_SAMPLE) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            idx_in = last_tone ? '0 : idx_ff + 1'b1;
            if (last_tone) begin
               state_in = (cnt_in == blen_ff) ? S_POW : S_IDLE;
            end
         end
         S_POW: begin
            if (pstat.done) begin
               idx_in = last_tone ? '0 : idx_ff + 1'b1;
               if (last_tone) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            idx_in = '0;
            if (post) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      drd_ff  <= dmem[idx_in];
      crd_ff  <= cmem[idx_in];
      dval_ff <= valid_ff[idx_in];
      if (state_ff == S_UPD) begin
         dmem[idx_ff] <= {vsat, d1};
      end
      if (accept && req_chan.kind == KIND_LOAD && 32'(req_chan.tone_select) < NUM_TONES) begin
         cmem[TONE_W'(req_chan.tone_select)] <= req_chan.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         blen_ff      <= BLOCK_LENGTH_RESET;
         margin_ff    <= DETECT_MARGIN_RESET;
         cnt_ff       <= '0;
         last_peak_ff <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BLOCK_LENGTH:  blen_ff   <= csr_wr_data[15:0];
               CSR_DETECT_MARGIN: margin_ff <= csr_wr_data[31:0];
               default:           blen_ff   <= blen_ff;
            endcase
         end
         if (accept && req_chan.kind == KIND_CLEAR) begin
            valid_ff     <= '0;
            cnt_ff       <= '0;
            last_peak_ff <= '0;
         end
         if (state_ff == S_UPD) begin
            valid_ff[idx_ff] <= 1'b1;
            if (last_tone) begin
               cnt_ff <= cnt_in;
            end
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (post) begin
            rsp_valid_ff <= 1'b1;
            valid_ff     <= '0;
            cnt_ff       <= '0;
            last_peak_ff <= pidx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.kind == KIND_SAMPLE) begin
         smp_ff <= req_chan.sample;
      end
      if (state_ff == S_UPD && last_tone) begin
         peak_ff <= '0;
         sum_ff  <= '0;
         pidx_ff <= last_peak_ff;
      end
      if (state_ff == S_POW && pstat.done) begin
         sum_ff <= sum_ff + SUM_W'(pstat.power);
         if (pstat.power > peak_ff) begin
            peak_ff <= pstat.power;
            pidx_ff <= 5'(idx_ff);
         end
      end
      if (post) begin
         rsp_det_ff   <= hit;
         rsp_tone_ff  <= pidx_ff;
         rsp_power_ff <= peak_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.tone_detected = rsp_det_ff;
   assign rsp_chan.peak_tone     = rsp_tone_ff;
   assign rsp_chan.peak_power    = rsp_power_ff;
endmodule
`default_nettype wire

// ===== rtl/core/gtbd_checker.sv =====
// Checker: port-level properties of the tone bank detector, bound to the top level.
`default_nettype none
module gtbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_kind,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_detected,
   input wire logic [47:0] rsp_power
);
   import gtbd_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_SAMPLE |=> !req_ready)
      else $error("sample sweep did not hold off requests");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result posted without a sweep");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power == 48'd0 |-> !rsp_detected)
      else $error("tone flagged with zero peak power");
endmodule

bind goertzel_tone_bank_detector_unit gtbd_checker u_gtbd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_kind     (req_chan.kind),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_detected (rsp_chan.tone_detected),
   .rsp_power    (rsp_chan.peak_power)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench: Goertzel tone bank detector against a cycle-free predictor of its results.
`timescale 1ns / 1ps
module tb_top;
   import gtbd_pkg::*;

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic [4:0]         tone_select;
      logic signed [15:0] coef_value;
   } tone_item_type;

   typedef struct {
      logic               detected;
      logic [4:0]         tone;
      logic [POWER_W-1:0] power;
   } tone_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   gtbd_req_if req_bus ();
   gtbd_rsp_if rsp_bus ();

   goertzel_tone_bank_detector_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus.sink),
      .rsp_chan    (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tone_item_type   pending_items[$];
   tone_result_type expected_results[$];
   tone_item_type   offered_item;
   int           items_queued;
   int           items_taken;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           hold_request;
   int           hold_left;
   bit           failed;

   logic signed [15:0] coef_bank[NUM_TONES];
   logic signed [31:0] delay_a[NUM_TONES];
   logic signed [31:0] delay_b[NUM_TONES];
   logic [15:0]        samples_seen;
   logic [15:0]        blk_len;
   logic [31:0]        margin;
   logic [4:0]         prev_peak;

   function automatic void clear_resonators();
      for (int j = 0; j < NUM_TONES; j++) begin
         delay_a[j] = '0;
         delay_b[j] = '0;
      end
      samples_seen = '0;
   endfunction

   function automatic void predict_tones(input tone_item_type it);
      longint signed nv;
      logic signed [127:0] acc, da, db, cw;
      logic [127:0] q;
      logic [63:0] p, peak, total;
      logic [4:0] idx;
      tone_result_type r;
      case (it.kind)
         KIND_LOAD: coef_bank[it.tone_select] = it.coef_value;
         KIND_CLEAR: begin
            clear_resonators();
            prev_peak = '0;
         end
         KIND_SAMPLE: begin
            for (int j = 0; j < NUM_TONES; j++) begin
               nv = (longint'(coef_bank[j]) * longint'(delay_a[j]) + 8192) >>> 14;
               nv = nv + longint'(it.sample) - longint'(delay_b[j]);
               if (nv > 64'sd2147483647) nv = 64'sd2147483647;
               if (nv < -64'sd2147483648) nv = -64'sd2147483648;
               delay_b[j] = delay_a[j];
               delay_a[j] = nv[31:0];
            end
            samples_seen = samples_seen + 16'd1;
            if (samples_seen == blk_len) begin
               peak = '0;
               total = '0;
               idx = prev_peak;
               for (int j = 0; j < NUM_TONES; j++) begin
                  da = delay_a[j];
                  db = delay_b[j];
                  cw = coef_bank[j];
                  acc = da * da * 16384 + db * db * 16384 - cw * da * db + 8192;
                  if (acc[127]) p = '0;
                  else begin
                     q = acc >>> 14;
                     p = (q > 128'(POWER_MAX)) ? 64'(POWER_MAX) : q[63:0];
                  end
                  total = total + p;
                  if (p > peak) begin
                     peak = p;
                     idx = j[4:0];
                  end
               end
               r.detected = (peak * NUM_TONES) > (total + 64'(margin) * NUM_TONES);
               r.tone = idx;
               r.power = peak[POWER_W-1:0];
               prev_peak = idx;
               clear_resonators();
               expected_results.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_tones(offered_item);
            items_taken <= items_taken + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_item = pending_items.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.kind        <= offered_item.kind;
               req_bus.sample      <= offered_item.sample;
               req_bus.tone_select <= offered_item.tone_select;
               req_bus.coef_value  <= offered_item.coef_value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      tone_result_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result det=%0b tone=%0d power=%0h", $time,
                        rsp_bus.tone_detected, rsp_bus.peak_tone, rsp_bus.peak_power);
               failed = 1'b1;
            end else begin
               e = expected_results.pop_front();
               if (rsp_bus.tone_detected !== e.detected) begin
                  $display("%0t: tone_detected expected %0b actual %0b", $time,
                           e.detected, rsp_bus.tone_detected);
                  failed = 1'b1;
               end
               if (rsp_bus.peak_tone !== e.tone) begin
                  $display("%0t: peak_tone expected %0d actual %0d", $time,
                           e.tone, rsp_bus.peak_tone);
                  failed = 1'b1;
               end
               if (rsp_bus.peak_power !== e.power) begin
                  $display("%0t: peak_power expected %0h actual %0h", $time,
                           e.power, rsp_bus.peak_power);
                  failed = 1'b1;
               end
            end
         end
         if (hold_request > 0 && hold_left == 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic queue_item(input logic [1:0] k, input logic signed [15:0] s,
                             input logic [4:0] t, input logic signed [15:0] c);
      tone_item_type it;
      it.kind = k;
      it.sample = s;
      it.tone_select = t;
      it.coef_value = c;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_random_item();
      int pick;
      logic signed [15:0] s;
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0: s = 16'($urandom);
         1: s = $signed(16'($urandom_range(2047))) - 16'sd1024;
         2: s = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
         default: s = 16'($urandom_range(8191));
      endcase
      if (pick < 86) queue_item(KIND_SAMPLE, s, 5'($urandom), 16'($urandom));
      else if (pick < 93) queue_item(KIND_LOAD, 16'($urandom), 5'($urandom), 16'($urandom));
      else if (pick < 97) queue_item(KIND_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom));
      else queue_item(KIND_UNUSED, 16'($urandom), 5'($urandom), 16'($urandom));
   endtask

   task automatic drain();
      while (items_taken != items_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (320) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      if (idx == CSR_BLOCK_LENGTH) blk_len = val[15:0];
      else margin = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int n, input logic [15:0] bl, input logic [31:0] mg,
                            input int s_idle, input int r_idle);
      write_csr(CSR_BLOCK_LENGTH, {16'd0, bl});
      write_csr(CSR_DETECT_MARGIN, mg);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      repeat (n) queue_random_item();
      queue_item(KIND_CLEAR, 16'sd0, 5'd0, 16'sd0);
      drain();
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_SAMPLE;
      req_bus.sample = '0;
      req_bus.tone_select = '0;
      req_bus.coef_value = '0;
      rsp_bus.ready = 1'b0;
      items_queued = 0;
      items_taken = 0;
      send_idle_pct = 30;
      recv_idle_pct = 56;
      hold_request = 0;
      hold_left = 0;
      failed = 1'b0;
      blk_len = BLOCK_LENGTH_RESET;
      margin = DETECT_MARGIN_RESET;
      prev_peak = '0;
      for (int j = 0; j < NUM_TONES; j++) coef_bank[j] = '0;
      clear_resonators();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_BLOCK_LENGTH, 32'd1);
      write_csr(CSR_DETECT_MARGIN, 32'd0);
      for (int j = 0; j < NUM_TONES; j++)
         queue_item(KIND_LOAD, 16'sd0, j[4:0],
                    (j == 0) ? 16'sh7fff : (j == 1) ? 16'sh8000 : 16'($urandom));
      queue_item(KIND_UNUSED, 16'sh7fff, 5'd31, 16'sh7fff);
      queue_item(KIND_SAMPLE, 16'sh7fff, 5'd0, 16'sd0);
      queue_item(KIND_SAMPLE, 16'sh8000, 5'd0, 16'sd0);
      queue_item(KIND_SAMPLE, 16'sd0, 5'd0, 16'sd0);
      queue_item(KIND_CLEAR, 16'sd0, 5'd0, 16'sd0);
      queue_item(KIND_SAMPLE, 16'sd0, 5'd0, 16'sd0);
      queue_item(KIND_SAMPLE, 16'sd12345, 5'd0, 16'sd0);
      drain();

      run_phase(300, 16'd3, DETECT_MARGIN_RESET, 30, 56);
      run_phase(10, 16'hffff, 32'hffff_ffff, 30, 56);
      run_phase(10, 16'd0, $urandom, 56, 30);
      hold_request = 3000;
      run_phase(300, 16'd7, 32'd0, 56, 30);
      run_phase(150, 16'd1, 32'hffff_ffff, 0, 0);
      run_phase(200, 16'd16, $urandom, 0, 0);

      if (!failed)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
